### design/tdeg_pkg.sv
`default_nettype none

package tdeg_pkg;

	// request codes carried in req_type
	localparam logic [2:0] REQ_SET      = 3'd0;
	localparam logic [2:0] REQ_FREE     = 3'd1;
	localparam logic [2:0] REQ_EXEC     = 3'd2;
	localparam logic [2:0] REQ_MMAP     = 3'd3;
	localparam logic [2:0] REQ_MPROTECT = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// one table word: valid bit, signed flag, device number
	typedef struct packed {
		logic        valid;
		logic        sig;
		logic [31:0] device;
	} entry_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic        is_verity_signature;
		logic        signature_present;
		logic        file_present;
		logic [31:0] mount_device;
		logic [31:0] data_device;
		logic        data_found;
		logic        exec_requested;
		logic        vm_exec_already;
	} req_t;

	typedef struct packed {
		logic [31:0] initramfs_device;
		logic        resolve_data_device;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic deny;
		logic status;
	} result_t;

endpackage

`default_nettype wire

### design/tdeg_table.sv
`default_nettype none

module tdeg_table import tdeg_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/tdeg_ctrl.sv
`default_nettype none

module tdeg_ctrl import tdeg_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire req_t          req,
	input  wire cfg_t          cfg,
	output logic               busy,
	output result_t            result,
	output logic               mem_rd_en,
	output logic [AW-1:0]      mem_rd_addr,
	input  wire entry_t        mem_rd_data,
	output logic               mem_wr_en,
	output logic [AW-1:0]      mem_wr_addr,
	output entry_t             mem_wr_data
);

	localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	req_t          req_q;
	logic [31:0]   key_q;
	logic          cmp_vld_s1;
	logic [AW-1:0] idx_s1;
	logic          found_q, found_sig_q, free_q;
	logic [AW-1:0] found_idx_q, free_idx_q;
	result_t       result_d, result_q;
	logic          accept, hit, empty;
	logic          init_trust, dev_deny, file_deny;

	assign accept = (state_q == ST_IDLE) && start;
	assign busy   = (state_q != ST_IDLE);
	assign result = result_q;

	assign hit   = cmp_vld_s1 && mem_rd_data.valid && (mem_rd_data.device == key_q);
	assign empty = cmp_vld_s1 && !mem_rd_data.valid;

	// verdicts from the finished scan
	assign init_trust = (cfg.initramfs_device != 32'd0) &&
	                    (req_q.mount_device == cfg.initramfs_device);
	assign dev_deny   = !(init_trust || (found_q && found_sig_q));
	assign file_deny  = (cfg.resolve_data_device && !req_q.data_found) ? 1'b1 : dev_deny;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_q == CNT_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == CNT_END) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = cnt_q[AW-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = cnt_q[AW-1:0];
		mem_wr_data = '0;
		result_d    = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			ST_SCAN: begin
				mem_rd_en = (cnt_q != CNT_END);
			end
			ST_DECIDE: begin
				result_d.done = 1'b1;
				case (req_q.req_type)
					REQ_SET: begin
						mem_wr_data.valid  = 1'b1;
						mem_wr_data.sig    = req_q.signature_present;
						mem_wr_data.device = req_q.mount_device;
						if (req_q.is_verity_signature) begin
							if (found_q) begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = found_idx_q;
							end else if (free_q) begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = free_idx_q;
							end else begin
								result_d.status = 1'b1;
							end
						end
					end
					REQ_FREE: begin
						mem_wr_en   = found_q;
						mem_wr_addr = found_idx_q;
					end
					REQ_EXEC: begin
						result_d.deny = file_deny;
					end
					REQ_MMAP: begin
						if (req_q.exec_requested)
							result_d.deny = req_q.file_present ? file_deny : 1'b1;
					end
					REQ_MPROTECT: begin
						if (req_q.exec_requested && !req_q.vm_exec_already)
							result_d.deny = req_q.file_present ? dev_deny : 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			state_q    <= state_d;
			result_q   <= result_d;
			cmp_vld_s1 <= mem_rd_en;
			if ((state_q == ST_CLEAR) || mem_rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end
			if (accept) begin
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (hit && !found_q)  found_q <= 1'b1;
				if (empty && !free_q) free_q  <= 1'b1;
			end
		end
	end

	// payload: item fields, search key, first-hit and first-free slots
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (accept) begin
			req_q <= req;
			if (cfg.resolve_data_device &&
			    ((req.req_type == REQ_EXEC) || (req.req_type == REQ_MMAP)))
				key_q <= req.data_device;
			else
				key_q <= req.mount_device;
		end
		if (hit && !found_q) begin
			found_idx_q <= idx_s1;
			found_sig_q <= mem_rd_data.sig;
		end
		if (empty && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

endmodule

`default_nettype wire

### design/trusted_device_exec_gate_top.sv
`default_nettype none

// Trusted device exec gate. Holds a table of TABLE_ENTRIES device numbers,
// each with a signed flag, in one synchronous RAM, and answers set, free,
// exec, mmap and mprotect requests. An item is taken when start is high and
// busy is low. Every item, known request type or not, runs one linear scan
// of the RAM (one read per cycle, read data registered in the RAM), then a
// decide state that writes back the entry for set and free requests and
// registers the verdict. done pulses for one cycle, registered from the
// decide state, with deny and status valid in that cycle; busy drops in that
// same cycle, so a new item may be taken at the edge that ends it; the gate
// takes no new item while one is in flight. The receiver cannot stall done:
// capture it when it pulses. After reset the RAM is cleared, one entry per
// cycle, with busy high; configuration writes are taken at any time but
// must only change while busy is low. Reads and the write-back never
// overlap in time, so no forwarding is needed.
module trusted_device_exec_gate_top import tdeg_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item in
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic        is_verity_signature,
	input  wire logic        signature_present,
	input  wire logic        file_present,
	input  wire logic [31:0] mount_device,
	input  wire logic [31:0] data_device,
	input  wire logic        data_found,
	input  wire logic        exec_requested,
	input  wire logic        vm_exec_already,
	// result out
	output logic             done,
	output logic             deny,
	output logic             status,
	// config writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// register indexes
	localparam logic CFG_INITRAMFS = 1'b0;
	localparam logic CFG_RESOLVE   = 1'b1;

	cfg_t          cfg_q;
	req_t          req;
	result_t       result;
	logic          mem_rd_en, mem_wr_en;
	logic [AW-1:0] mem_rd_addr, mem_wr_addr;
	entry_t        mem_rd_data, mem_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITRAMFS: cfg_q.initramfs_device    <= cfg_wdata;
				CFG_RESOLVE:   cfg_q.resolve_data_device <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		req.req_type            = req_type;
		req.is_verity_signature = is_verity_signature;
		req.signature_present   = signature_present;
		req.file_present        = file_present;
		req.mount_device        = mount_device;
		req.data_device         = data_device;
		req.data_found          = data_found;
		req.exec_requested      = exec_requested;
		req.vm_exec_already     = vm_exec_already;
	end

	// scan sequencer and verdict logic
	tdeg_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.cfg        (cfg_q),
		.busy       (busy),
		.result     (result),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data)
	);

	// device table RAM
	tdeg_table #(
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	assign done   = result.done;
	assign deny   = result.deny;
	assign status = result.status;

	// a result only shows once the sequencer is back to taking items
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted item always starts a scan
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accept did not start scan");

	// verdict bits only qualify a done pulse
	a_flags_done: assert property (@(posedge clk) disable iff (!arst_n)
		(deny || status) |-> done)
		else $error("deny or status without done");

	// one result per item: never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held two cycles");

endmodule

`default_nettype wire
